### hw/rtl/cgmc_pkg.sv
// Shared constants, codes, types and lane helper for the copolymer growth step block.
`default_nettype none
package cgmc_pkg;

   localparam int MAX_LENGTH  = 4096;
   localparam int PROB_BITS   = 16;
   localparam int LEN_W       = $clog2(MAX_LENGTH + 1);
   localparam int TARGET_W    = 13;
   localparam int CMP_W       = (LEN_W > TARGET_W) ? LEN_W : TARGET_W;
   localparam int THR_W       = 4 * PROB_BITS;
   localparam int CSR_W       = (THR_W > TARGET_W) ? THR_W : TARGET_W;
   localparam int REQ_W       = 2 * PROB_BITS;
   localparam int REQ_TDATA_W = ((REQ_W + 7) / 8) * 8;
   localparam int RSP_W       = 2 + 2 + 2 * LEN_W + 1;
   localparam int RSP_TDATA_W = ((RSP_W + 7) / 8) * 8;

   localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(3000);

   typedef enum logic [1:0] {
      CSR_CHOOSE = 2'd0,
      CSR_ADD    = 2'd1,
      CSR_REMOVE = 2'd2,
      CSR_TARGET = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_NONE       = 2'd0,
      ACT_PUSH_RIGHT = 2'd1,
      ACT_PUSH_WRONG = 2'd2,
      ACT_POP        = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      TR_FWD_RIGHT  = 2'd0,
      TR_FWD_WRONG  = 2'd1,
      TR_BACK_RIGHT = 2'd2,
      TR_BACK_WRONG = 2'd3
   } transition_type;

   // shift control for the cell row; monomer is what enters cell 0 on a push
   typedef struct packed {
      logic push;
      logic pop;
      logic monomer;
   } stack_ctrl_type;

   typedef struct packed {
      logic           done;
      logic [LEN_W-1:0] wrong;
      logic [LEN_W-1:0] length;
      transition_type trans;
      action_type     action;
   } result_type;

   function automatic logic [PROB_BITS-1:0] lane_sel(input logic [THR_W-1:0] r,
                                                     input logic [1:0] idx);
      logic [PROB_BITS-1:0] v;
      case (idx)
         2'd0:    v = r[0*PROB_BITS +: PROB_BITS];
         2'd1:    v = r[1*PROB_BITS +: PROB_BITS];
         2'd2:    v = r[2*PROB_BITS +: PROB_BITS];
         default: v = r[3*PROB_BITS +: PROB_BITS];
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/cgmc_cell.sv
// One cell of the monomer stack: holds one monomer, shifts down on push, up on pop.
`default_nettype none
module cgmc_cell
   import cgmc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire stack_ctrl_type ctrl,
   input  wire logic           from_above,
   input  wire logic           from_below,
   output logic                monomer
);

   logic monomer_ff;
   logic monomer_in;

   always_comb begin
      monomer_in = monomer_ff;
      if (ctrl.push) begin
         monomer_in = from_above;
      end else if (ctrl.pop) begin
         monomer_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         monomer_ff <= 1'b0;
      end else begin
         monomer_ff <= monomer_in;
      end
   end

   assign monomer = monomer_ff;

endmodule
`default_nettype wire

### hw/rtl/cgmc_step.sv
// Step decision: picks the transition, tests acceptance, keeps length and wrong counters.
`default_nettype none
module cgmc_step
   import cgmc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 go,
   input  wire logic [PROB_BITS-1:0] choice_draw,
   input  wire logic [PROB_BITS-1:0] accept_draw,
   input  wire logic                 tip,
   input  wire logic                 prev,
   input  wire logic [THR_W-1:0]     choose_thr,
   input  wire logic [THR_W-1:0]     add_thr,
   input  wire logic [THR_W-1:0]     remove_thr,
   input  wire logic [TARGET_W-1:0]  target_length,
   output stack_ctrl_type            stack_ctrl,
   output result_type                result
);

   localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_LENGTH);

   logic [LEN_W-1:0] length_ff, length_in;
   logic [LEN_W-1:0] wrong_ff, wrong_in;

   logic [CMP_W-1:0]     target_c;
   logic [CMP_W-1:0]     length_c;
   logic                 active;
   transition_type       trans;
   logic [PROB_BITS-1:0] t_right, t_fwd, add_p, rem_p;
   logic                 do_push, do_pop;
   action_type           action;

   always_comb begin
      target_c = (CMP_W'(target_length) > MAX_C) ? MAX_C : CMP_W'(target_length);
      length_c = CMP_W'(length_ff);
      active   = length_c < target_c;

      t_right = lane_sel(choose_thr, {prev, 1'b0});
      t_fwd   = lane_sel(choose_thr, {prev, 1'b1});

      trans = TR_FWD_RIGHT;
      if (active) begin
         if (length_ff == LEN_W'(1)) begin
            // a lone monomer only grows, half each way
            trans = choice_draw[PROB_BITS-1] ? TR_FWD_WRONG : TR_FWD_RIGHT;
         end else if (choice_draw < t_right) begin
            trans = TR_FWD_RIGHT;
         end else if (choice_draw < t_fwd) begin
            trans = TR_FWD_WRONG;
         end else begin
            trans = prev ? TR_BACK_WRONG : TR_BACK_RIGHT;
         end
      end

      add_p = lane_sel(add_thr, {trans[0], tip});
      rem_p = lane_sel(remove_thr, {trans[0], tip});

      do_push = go && active && !trans[1] && (accept_draw < add_p) && (length_c < MAX_C);
      do_pop  = go && active && trans[1] && (accept_draw < rem_p)
                && (length_ff > LEN_W'(1));

      length_in = length_ff;
      wrong_in  = wrong_ff;
      action    = ACT_NONE;
      if (do_push) begin
         length_in = length_ff + LEN_W'(1);
         if (trans[0]) begin
            wrong_in = wrong_ff + LEN_W'(1);
            action   = ACT_PUSH_WRONG;
         end else begin
            action   = ACT_PUSH_RIGHT;
         end
      end else if (do_pop) begin
         length_in = length_ff - LEN_W'(1);
         if (tip && (wrong_ff != '0)) begin
            wrong_in = wrong_ff - LEN_W'(1);
         end
         action = ACT_POP;
      end

      stack_ctrl.push    = do_push;
      stack_ctrl.pop     = do_pop;
      stack_ctrl.monomer = trans[0];

      result.action = action;
      result.trans  = trans;
      result.length = length_in;
      result.wrong  = wrong_in;
      result.done   = CMP_W'(length_in) >= target_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LEN_W'(1);
         wrong_ff  <= '0;
      end else if (go) begin
         length_ff <= length_in;
         wrong_ff  <= wrong_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/copolymer_growth_monte_carlo_step.sv
// Copolymer growth step top level: configuration, stack cell row, step logic, output buffer.
//
// Use: each word on the req_ stream is one Monte Carlo step carrying two Q0.16 draws
// (choice_draw in bits 15:0, accept_draw in bits 31:16). Each accepted word yields
// exactly one rsp_ word with the action taken, the transition state chosen, the new
// polymer length, the wrong-monomer count and a done flag.
// The result is registered in the output buffer before it shows on rsp_.
// Throughput: one word per cycle while req_tready is high. The monomer stack is a shift
// row of MAX_LENGTH one-bit cells, so the tip and the monomer below it always sit in
// cells 0 and 1; a push or pop moves the whole row at once.
// A two-word output buffer sits between the sides: req_tready drops only when both
// entries hold unread results, so a stalled receiver stops intake after two words.
// Registers are written on csr_we with csr_index 0..3 (choose, add, remove, target); the
// user must write them only while no step is outstanding; the block does not enforce it.
// Reset (synchronous): thresholds zero, target 3000, length one with a right monomer,
// no wrong monomers, output buffer empty.
`default_nettype none
module copolymer_growth_monte_carlo_step
   import cgmc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // req_tdata: choice_draw, accept_draw
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata: action, transition, polymer_length, wrong_count, done_res, zero fill
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire logic                   csr_we,
   input  wire logic [1:0]             csr_index,
   input  wire logic [CSR_W-1:0]       csr_wdata
);

   logic [THR_W-1:0]    choose_thr_ff, add_thr_ff, remove_thr_ff;
   logic [TARGET_W-1:0] target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         choose_thr_ff <= '0;
         add_thr_ff    <= '0;
         remove_thr_ff <= '0;
         target_ff     <= TARGET_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CHOOSE: choose_thr_ff <= csr_wdata[THR_W-1:0];
            CSR_ADD:    add_thr_ff    <= csr_wdata[THR_W-1:0];
            CSR_REMOVE: remove_thr_ff <= csr_wdata[THR_W-1:0];
            CSR_TARGET: target_ff     <= csr_wdata[TARGET_W-1:0];
            default: ;
         endcase
      end
   end

   logic           req_accept;
   stack_ctrl_type stack_ctrl;
   result_type     step_result;
   logic [MAX_LENGTH-1:0] stack_bits;

   assign req_accept = req_tvalid && req_tready;

   cgmc_step u_step (
      .clock         (clock),
      .reset         (reset),
      .go            (req_accept),
      .choice_draw   (req_tdata[PROB_BITS-1:0]),
      .accept_draw   (req_tdata[2*PROB_BITS-1:PROB_BITS]),
      .tip           (stack_bits[0]),
      .prev          (stack_bits[1]),
      .choose_thr    (choose_thr_ff),
      .add_thr       (add_thr_ff),
      .remove_thr    (remove_thr_ff),
      .target_length (target_ff),
      .stack_ctrl    (stack_ctrl),
      .result        (step_result)
   );

   // cell 0 is the tip; a push shifts towards higher cells, a pop back towards cell 0
   for (genvar g = 0; g < MAX_LENGTH; g++) begin : g_cell
      logic above, below;
      if (g == 0) begin : g_first
         assign above = stack_ctrl.monomer;
      end else begin : g_mid_a
         assign above = stack_bits[g-1];
      end
      if (g == MAX_LENGTH - 1) begin : g_last
         assign below = 1'b0;
      end else begin : g_mid_b
         assign below = stack_bits[g+1];
      end
      cgmc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (stack_ctrl),
         .from_above (above),
         .from_below (below),
         .monomer    (stack_bits[g])
      );
   end

   // two-word output buffer: head drives rsp_, second catches a word during a stall
   logic [RSP_W-1:0] new_word;
   logic [RSP_W-1:0] head_ff, head_in, second_ff, second_in;
   logic [1:0]       count_ff, count_in;
   logic             rsp_take;

   assign new_word = {step_result.done, step_result.wrong, step_result.length,
                      step_result.trans, step_result.action};
   assign rsp_take = rsp_tvalid && rsp_tready;

   always_comb begin
      head_in   = head_ff;
      second_in = second_ff;
      count_in  = count_ff;
      case (count_ff)
         2'd0: begin
            if (req_accept) begin
               head_in  = new_word;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (req_accept && rsp_take) begin
               head_in = new_word;
            end else if (req_accept) begin
               second_in = new_word;
               count_in  = 2'd2;
            end else if (rsp_take) begin
               count_in = 2'd0;
            end
         end
         default: begin
            if (rsp_take) begin
               head_in  = second_ff;
               count_in = 2'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff   <= head_in;
      second_ff <= second_in;
   end

   assign req_tready = (count_ff != 2'd2);
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = RSP_TDATA_W'(head_ff);

`ifndef SYNTHESIS
   a_push_pop_excl: assert property (@(posedge clock) disable iff (reset)
      !(stack_ctrl.push && stack_ctrl.pop))
      else $error("stack pushed and popped in one cycle");

   a_shift_needs_word: assert property (@(posedge clock) disable iff (reset)
      (stack_ctrl.push || stack_ctrl.pop) |-> req_accept)
      else $error("stack moved without an accepted word");

   a_push_lands_tip: assert property (@(posedge clock) disable iff (reset)
      stack_ctrl.push |=> stack_bits[0] == $past(stack_ctrl.monomer))
      else $error("pushed monomer missing from tip cell");

   a_pop_lifts_row: assert property (@(posedge clock) disable iff (reset)
      stack_ctrl.pop |=> stack_bits[0] == $past(stack_bits[1]))
      else $error("pop did not bring the monomer below up to the tip");
`endif

endmodule
`default_nettype wire
